// ----- rtl/fac_pkg.sv -----
package fac_pkg;

    localparam int FAC_PLANE_COUNT = 6;
    localparam int FAC_FRAC_BITS   = 16;
    localparam int FAC_ROWS        = 3;

    localparam logic [1:0] OP_PLANE = 2'd0;
    localparam logic [1:0] OP_ROW   = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    localparam logic signed [31:0] FAC_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] FAC_MIN = 32'sh8000_0000;

    // destination of a finished sum
    typedef enum logic [1:0] {
        DST_CW   = 2'd0,
        DST_EW   = 2'd1,
        DST_RAD  = 2'd2,
        DST_DIST = 2'd3
    } t_dest;

    typedef struct packed {
        logic       fin_item;
        t_dest      kind;
        logic [1:0] idx;
    } t_tag;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        t_tag tag;
    } t_mac_req;

    typedef struct packed {
        logic fin;
        t_tag tag;
    } t_mac_rsp;

    typedef struct packed {
        logic       plane_we;
        logic       row_we;
        logic [2:0] slot;
    } t_load;

    function automatic logic signed [31:0] f_abs_sat(input logic signed [31:0] v);
        logic signed [31:0] res;
        if (v == FAC_MIN) begin
            res = FAC_MAX;
        end else if (v[31]) begin
            res = -v;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ----- rtl/fac_mac.sv -----
module fac_mac
    import fac_pkg::*;
#(
    parameter int FRAC_BITS = FAC_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac_req           i_req,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output t_mac_rsp           o_rsp,
    output logic signed [31:0] o_acc
);

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    logic signed [63:0] r_prod;
    t_mac_req           r_s1;
    logic signed [31:0] r_acc;
    logic               r_fin;
    t_tag               r_tag;

    logic signed [63:0] w_sh;
    logic signed [31:0] w_p;
    logic signed [31:0] w_base;
    logic signed [32:0] w_sum;
    logic signed [31:0] n_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    always_comb begin
        // floor shift back to the fixed-point scale, then clamp the product
        w_sh = r_prod >>> FRAC_BITS;
        if (w_sh > SAT_HI) begin
            w_p = FAC_MAX;
        end else if (w_sh < SAT_LO) begin
            w_p = FAC_MIN;
        end else begin
            w_p = w_sh[31:0];
        end
        w_base = r_s1.first ? 32'sd0 : r_acc;
        w_sum  = {w_base[31], w_base} + {w_p[31], w_p};
        if (w_sum[32] != w_sum[31]) begin
            n_acc = w_sum[32] ? FAC_MIN : FAC_MAX;
        end else begin
            n_acc = w_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_fin <= 1'b0;
        end else begin
            r_s1  <= i_req;
            r_fin <= r_s1.valid && r_s1.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            r_acc <= n_acc;
            r_tag <= r_s1.tag;
        end
    end

    assign o_rsp.fin = r_fin;
    assign o_rsp.tag = r_tag;
    assign o_acc     = r_acc;

endmodule

// ----- rtl/fac_store.sv -----
module fac_store
    import fac_pkg::*;
#(
    parameter int PLANE_COUNT = FAC_PLANE_COUNT,
    localparam int PIDX_W     = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_load              i_load,
    input  logic signed [31:0] i_coef_x,
    input  logic signed [31:0] i_coef_y,
    input  logic signed [31:0] i_coef_z,
    input  logic signed [31:0] i_coef_w,
    input  logic [PIDX_W-1:0]  i_pidx,
    input  logic [1:0]         i_row,
    input  logic [1:0]         i_col,
    output logic signed [31:0] o_nx,
    output logic signed [31:0] o_ny,
    output logic signed [31:0] o_nz,
    output logic signed [31:0] o_off,
    output logic signed [31:0] o_mcoef
);

    logic signed [31:0] r_nx  [PLANE_COUNT];
    logic signed [31:0] r_ny  [PLANE_COUNT];
    logic signed [31:0] r_nz  [PLANE_COUNT];
    logic signed [31:0] r_off [PLANE_COUNT];
    logic signed [31:0] r_world [FAC_ROWS][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                r_nx[i]  <= '0;
                r_ny[i]  <= '0;
                r_nz[i]  <= '0;
                r_off[i] <= '0;
            end
            for (int i = 0; i < FAC_ROWS; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_world[i][j] <= '0;
                end
            end
        end else begin
            if (i_load.plane_we) begin
                r_nx[i_load.slot[PIDX_W-1:0]]  <= i_coef_x;
                r_ny[i_load.slot[PIDX_W-1:0]]  <= i_coef_y;
                r_nz[i_load.slot[PIDX_W-1:0]]  <= i_coef_z;
                r_off[i_load.slot[PIDX_W-1:0]] <= i_coef_w;
            end
            if (i_load.row_we) begin
                r_world[i_load.slot[1:0]][0] <= i_coef_x;
                r_world[i_load.slot[1:0]][1] <= i_coef_y;
                r_world[i_load.slot[1:0]][2] <= i_coef_z;
                r_world[i_load.slot[1:0]][3] <= i_coef_w;
            end
        end
    end

    assign o_nx    = r_nx[i_pidx];
    assign o_ny    = r_ny[i_pidx];
    assign o_nz    = r_nz[i_pidx];
    assign o_off   = r_off[i_pidx];
    assign o_mcoef = r_world[i_row][i_col];

endmodule

// ----- rtl/frustum_aabb_cull.sv -----
// Channel  | Dir | Fields
// s_axis   | in  | tuser: op, slot; tdata: coef_x..coef_w, box_min_x..z, box_max_x..z
// m_axis   | out | tdata: visible (one item per box test)
//
// Plane and matrix loads are written into the stores when accepted. A box test
// runs as the accepting cycle, then every product through one shared
// multiply-accumulate unit, one term a cycle, then a drain of the multiply pipeline
// and a finish step that posts the result.
// Synchronous active-low reset clears the plane and matrix stores to zero.
// The input is stalled for the whole of a test; a result that is not taken holds
// the end of the next test until the output register is free.
module frustum_aabb_cull
    import fac_pkg::*;
#(
    parameter int PLANE_COUNT = FAC_PLANE_COUNT,
    parameter int FRAC_BITS   = FAC_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [319:0] s_axis_tdata,  // coef_x, coef_y, coef_z, coef_w, box_min_x,
                                        // box_min_y, box_min_z, box_max_x, box_max_y,
                                        // box_max_z (32 bits each)
    input  logic [4:0]   s_axis_tuser,  // op [1:0], slot [4:2]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata   // visible [0], zero above
);

    localparam int PIDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
    localparam int GRP_W  = $clog2((PLANE_COUNT > FAC_ROWS) ? PLANE_COUNT : FAC_ROWS);
    localparam logic [GRP_W-1:0] LAST_PLANE = GRP_W'(PLANE_COUNT - 1);
    localparam logic [GRP_W-1:0] LAST_ROW   = GRP_W'(FAC_ROWS - 1);
    localparam logic signed [31:0] ONE      = 32'(64'd1 << FRAC_BITS);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_XFORM  = 5'b00010,
        ST_PLANE  = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state             r_state;
    logic [GRP_W-1:0]   r_grp;
    logic               r_sum;
    logic [1:0]         r_term;
    logic signed [31:0] r_c  [3];
    logic signed [31:0] r_e  [3];
    logic signed [31:0] r_cw [3];
    logic signed [31:0] r_ew [3];
    logic signed [31:0] r_rad;
    logic               r_culled;
    logic               r_pend_vis;
    logic               r_out_valid;
    logic               r_out_vis;

    logic [1:0]         w_op;
    logic [2:0]         w_slot;
    logic               w_acc;
    t_load              w_load;
    t_mac_req           w_req;
    t_mac_rsp           w_rsp;
    logic signed [31:0] w_acc_val;
    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic [1:0]         w_last_term;
    logic signed [31:0] w_nx, w_ny, w_nz, w_off, w_mcoef;
    logic signed [31:0] w_nsel;
    logic signed [33:0] w_dr;
    logic               w_cull_now;
    logic signed [32:0] w_hs [3];
    logic signed [32:0] w_hd [3];

    assign w_op          = s_axis_tuser[1:0];
    assign w_slot        = s_axis_tuser[4:2];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign w_load.plane_we = w_acc && (w_op == OP_PLANE) && (32'(w_slot) < PLANE_COUNT);
    assign w_load.row_we   = w_acc && (w_op == OP_ROW) && (32'(w_slot) < FAC_ROWS);
    assign w_load.slot     = w_slot;

    fac_store #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_coef_x (s_axis_tdata[31:0]),
        .i_coef_y (s_axis_tdata[63:32]),
        .i_coef_z (s_axis_tdata[95:64]),
        .i_coef_w (s_axis_tdata[127:96]),
        .i_pidx   (r_grp[PIDX_W-1:0]),
        .i_row    (r_grp[1:0]),
        .i_col    (r_term),
        .o_nx     (w_nx),
        .o_ny     (w_ny),
        .o_nz     (w_nz),
        .o_off    (w_off),
        .o_mcoef  (w_mcoef)
    );

    // centre and half extent, floored, at full width
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_hs[i] = {s_axis_tdata[128 + 32*i + 96 + 31], s_axis_tdata[128 + 32*i + 96 +: 32]}
                    + {s_axis_tdata[128 + 32*i + 31], s_axis_tdata[128 + 32*i +: 32]};
            w_hd[i] = {s_axis_tdata[128 + 32*i + 96 + 31], s_axis_tdata[128 + 32*i + 96 +: 32]}
                    - {s_axis_tdata[128 + 32*i + 31], s_axis_tdata[128 + 32*i +: 32]};
        end
    end

    always_comb begin
        w_last_term = ((r_state == ST_XFORM && !r_sum) || (r_state == ST_PLANE && r_sum))
                    ? 2'd3 : 2'd2;

        case (r_term)
            2'd0:    w_nsel = w_nx;
            2'd1:    w_nsel = w_ny;
            2'd2:    w_nsel = w_nz;
            default: w_nsel = w_off;
        endcase

        w_a = w_mcoef;
        w_b = ONE;
        w_req.tag.kind = DST_CW;
        if (r_state == ST_XFORM) begin
            if (!r_sum) begin
                w_a = w_mcoef;
                w_b = (r_term == 2'd3) ? ONE : r_c[r_term];
                w_req.tag.kind = DST_CW;
            end else begin
                w_a = f_abs_sat(w_mcoef);
                w_b = r_e[r_term];
                w_req.tag.kind = DST_EW;
            end
        end else begin
            if (!r_sum) begin
                w_a = r_ew[r_term];
                w_b = f_abs_sat(w_nsel);
                w_req.tag.kind = DST_RAD;
            end else begin
                w_a = w_nsel;
                w_b = (r_term == 2'd3) ? ONE : r_cw[r_term];
                w_req.tag.kind = DST_DIST;
            end
        end

        w_req.valid        = (r_state == ST_XFORM) || (r_state == ST_PLANE);
        w_req.first        = (r_term == 2'd0);
        w_req.last         = (r_term == w_last_term);
        w_req.tag.idx      = r_grp[1:0];
        w_req.tag.fin_item = (r_state == ST_PLANE) && r_sum && (r_grp == LAST_PLANE)
                           && (r_term == w_last_term);
    end

    fac_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_rsp   (w_rsp),
        .o_acc   (w_acc_val)
    );

    // culled when d + r < 0, exact at full width
    assign w_dr       = {{2{w_acc_val[31]}}, w_acc_val} + {{2{r_rad[31]}}, r_rad};
    assign w_cull_now = w_rsp.fin && (w_rsp.tag.kind == DST_DIST) && w_dr[33];

    always_ff @(posedge i_clk) begin
        if (w_acc && w_op == OP_TEST) begin
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= w_hs[i][32:1];
                r_e[i] <= w_hd[i][32:1];
            end
        end
        if (w_rsp.fin) begin
            case (w_rsp.tag.kind)
                DST_CW:  r_cw[w_rsp.tag.idx] <= w_acc_val;
                DST_EW:  r_ew[w_rsp.tag.idx] <= w_acc_val;
                DST_RAD: r_rad <= w_acc_val;
                default: ;
            endcase
        end
        if (w_rsp.fin && w_rsp.tag.fin_item) begin
            r_pend_vis <= !(r_culled || w_cull_now);
        end
        if (r_state == ST_FINISH && (!r_out_valid || m_axis_tready)) begin
            r_out_vis <= r_pend_vis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_grp       <= '0;
            r_sum       <= 1'b0;
            r_term      <= '0;
            r_culled    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end
            if (w_cull_now) begin
                r_culled <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc && w_op == OP_TEST) begin
                        r_grp    <= '0;
                        r_sum    <= 1'b0;
                        r_term   <= '0;
                        r_culled <= 1'b0;
                        r_state  <= ST_XFORM;
                    end
                end
                ST_XFORM, ST_PLANE: begin
                    if (r_term == w_last_term) begin
                        r_term <= '0;
                        r_sum  <= !r_sum;
                        if (r_sum) begin
                            if (r_state == ST_XFORM && r_grp == LAST_ROW) begin
                                r_grp   <= '0;
                                r_state <= ST_PLANE;
                            end else if (r_state == ST_PLANE && r_grp == LAST_PLANE) begin
                                r_state <= ST_DRAIN;
                            end else begin
                                r_grp <= r_grp + 1'b1;
                            end
                        end
                    end else begin
                        r_term <= r_term + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (w_rsp.fin && w_rsp.tag.fin_item) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // hold until the output register is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_vis};

    a_issue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.valid |-> (r_state == ST_XFORM || r_state == ST_PLANE))
        else $error("multiply issued outside a test");

    a_final_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rsp.fin && w_rsp.tag.fin_item) |-> (r_state == ST_DRAIN))
        else $error("final distance arrived outside drain");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FINISH))
        else $error("result raised without a finished test");

    a_test_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_op == OP_TEST) |=> (r_state == ST_XFORM && r_term == 2'd0))
        else $error("box test did not start the transform");

endmodule

// ----- tb/sv/frustum_aabb_cull_tb.sv -----
`timescale 1ns / 100ps

module frustum_aabb_cull_tb;
    import fac_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         ITEM_TARGET = 800;
    localparam int         IDLE_LIMIT  = 3000;
    localparam int         TAIL_CYCLES = 100;
    localparam int         HOLD_CYCLES = 400;
    localparam int         HOLD_AT     = 60;
    localparam int         PAUSE_AT    = 400;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] Q_TEN = 32'h000a_0000;

    typedef struct packed {
        logic [4:0]   user;
        logic [319:0] data;
    } t_in_item;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [319:0] s_axis_tdata = '0;
    logic [4:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;

    frustum_aabb_cull u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of the plane and matrix stores
    longint plane_nx [FAC_PLANE_COUNT];
    longint plane_ny [FAC_PLANE_COUNT];
    longint plane_nz [FAC_PLANE_COUNT];
    longint plane_off[FAC_PLANE_COUNT];
    longint world_m  [4 * FAC_ROWS];

    t_in_item pending_q[$];
    bit       exp_visible_q[$];

    int   err_cnt = 0;
    int   results_seen = 0;
    int   items_sent = 0;
    int   snd_gap = 0;
    int   rcv_wait = 0;
    bit   snd_busy = 1'b0;
    bit   pause_done = 1'b0;
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    int   idle_cycles = 0;

    function automatic longint sat_q(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    function automatic longint mul_q(input longint a, input longint b);
        return sat_q((a * b) >>> FAC_FRAC_BITS);
    endfunction

    function automatic longint add_q(input longint a, input longint b);
        return sat_q(a + b);
    endfunction

    function automatic longint abs_q(input longint a);
        return sat_q(a < 0 ? -a : a);
    endfunction

    // update the stores or work out the visibility of one accepted item
    task automatic apply_item(input logic [4:0] user, input logic [319:0] data);
        logic [1:0] op;
        logic [2:0] slot;
        longint     f[10];
        longint     ctr[3], ext[3], ctr_w[3], ext_w[3];
        longint     acc, rad, dval;
        bit         vis;
        int         i;
        op   = user[1:0];
        slot = user[4:2];
        for (i = 0; i < 10; i++) begin
            f[i] = longint'($signed(data[32*i +: 32]));
        end
        case (op)
            OP_PLANE: begin
                if (slot < FAC_PLANE_COUNT) begin
                    plane_nx[slot]  = f[0];
                    plane_ny[slot]  = f[1];
                    plane_nz[slot]  = f[2];
                    plane_off[slot] = f[3];
                end
            end
            OP_ROW: begin
                if (slot < FAC_ROWS) begin
                    for (i = 0; i < 4; i++) begin
                        world_m[4 * slot + i] = f[i];
                    end
                end
            end
            OP_TEST: begin
                for (i = 0; i < 3; i++) begin
                    ctr[i] = (f[7 + i] + f[4 + i]) >>> 1;
                    ext[i] = (f[7 + i] - f[4 + i]) >>> 1;
                end
                for (i = 0; i < FAC_ROWS; i++) begin
                    acc = mul_q(world_m[4*i], ctr[0]);
                    acc = add_q(acc, mul_q(world_m[4*i + 1], ctr[1]));
                    acc = add_q(acc, mul_q(world_m[4*i + 2], ctr[2]));
                    ctr_w[i] = add_q(acc, world_m[4*i + 3]);
                    acc = mul_q(abs_q(world_m[4*i]), ext[0]);
                    acc = add_q(acc, mul_q(abs_q(world_m[4*i + 1]), ext[1]));
                    ext_w[i] = add_q(acc, mul_q(abs_q(world_m[4*i + 2]), ext[2]));
                end
                vis = 1'b1;
                for (i = 0; i < FAC_PLANE_COUNT; i++) begin
                    rad  = mul_q(ext_w[0], abs_q(plane_nx[i]));
                    rad  = add_q(rad, mul_q(ext_w[1], abs_q(plane_ny[i])));
                    rad  = add_q(rad, mul_q(ext_w[2], abs_q(plane_nz[i])));
                    dval = mul_q(plane_nx[i], ctr_w[0]);
                    dval = add_q(dval, mul_q(plane_ny[i], ctr_w[1]));
                    dval = add_q(dval, mul_q(plane_nz[i], ctr_w[2]));
                    dval = add_q(dval, plane_off[i]);
                    if (dval < -rad) vis = 1'b0;
                end
                exp_visible_q.push_back(vis);
            end
            default: ;
        endcase
    endtask

    task automatic queue_item(input logic [1:0] op, input logic [2:0] slot,
                              input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [31:0] cw,
                              input logic [31:0] lx, input logic [31:0] ly,
                              input logic [31:0] lz, input logic [31:0] hx,
                              input logic [31:0] hy, input logic [31:0] hz);
        t_in_item it;
        it.user = {slot, op};
        it.data = {hz, hy, hx, lz, ly, lx, cw, cz, cy, cx};
        pending_q.push_back(it);
    endtask

    // mostly moderate magnitudes, with full-range words and extremes mixed in
    function automatic logic [31:0] rand_q();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom();
            1: begin
                case ($urandom_range(0, 3))
                    0: v = FAC_MIN;
                    1: v = FAC_MAX;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            2: v = $urandom_range(0, 32'h0002_0000);
            default: v = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        endcase
        return v;
    endfunction

    task automatic queue_random(input logic [1:0] op, input logic [2:0] slot);
        queue_item(op, slot, rand_q(), rand_q(), rand_q(), rand_q(),
                   rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
    endtask

    task automatic queue_directed();
        queue_item(OP_TEST, 3'd0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_item(OP_ROW, 3'd0, Q_ONE, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_item(OP_ROW, 3'd1, '0, Q_ONE, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_item(OP_ROW, 3'd2, '0, '0, Q_ONE, '0, '0, '0, '0, '0, '0, '0);
        // axis-aligned box of half-size ten
        queue_item(OP_PLANE, 3'd0, Q_ONE, '0, '0, Q_TEN, '0, '0, '0, '0, '0, '0);
        queue_item(OP_PLANE, 3'd1, -Q_ONE, '0, '0, Q_TEN, '0, '0, '0, '0, '0, '0);
        queue_item(OP_PLANE, 3'd2, '0, Q_ONE, '0, Q_TEN, '0, '0, '0, '0, '0, '0);
        queue_item(OP_PLANE, 3'd3, '0, -Q_ONE, '0, Q_TEN, '0, '0, '0, '0, '0, '0);
        queue_item(OP_PLANE, 3'd4, '0, '0, Q_ONE, Q_TEN, '0, '0, '0, '0, '0, '0);
        queue_item(OP_PLANE, 3'd5, '0, '0, -Q_ONE, Q_TEN, '0, '0, '0, '0, '0, '0);
        queue_item(OP_TEST, 3'd0, '0, '0, '0, '0,
                   -Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        queue_item(OP_TEST, 3'd0, '0, '0, '0, '0,
                   32'h0064_0000, '0, '0, 32'h0065_0000, Q_ONE, Q_ONE);
        // inverted box
        queue_item(OP_TEST, 3'd0, '0, '0, '0, '0,
                   32'h0014_0000, Q_ONE, Q_ONE, -32'h0014_0000, -Q_ONE, -Q_ONE);
        // undefined opcode and out-of-range slots must leave the stores alone
        queue_item(OP_UNUSED, 3'd0, FAC_MIN, FAC_MIN, FAC_MIN, FAC_MIN,
                   '0, '0, '0, '0, '0, '0);
        queue_item(OP_PLANE, 3'd6, FAC_MIN, FAC_MIN, FAC_MIN, FAC_MIN,
                   '0, '0, '0, '0, '0, '0);
        queue_item(OP_PLANE, 3'd7, FAC_MAX, FAC_MAX, FAC_MAX, FAC_MIN,
                   '0, '0, '0, '0, '0, '0);
        queue_item(OP_ROW, 3'd3, FAC_MIN, FAC_MIN, FAC_MIN, FAC_MIN,
                   '0, '0, '0, '0, '0, '0);
        queue_item(OP_ROW, 3'd7, FAC_MAX, FAC_MAX, FAC_MAX, FAC_MAX,
                   '0, '0, '0, '0, '0, '0);
        queue_item(OP_TEST, 3'd0, '0, '0, '0, '0,
                   32'h0064_0000, '0, '0, 32'h0065_0000, Q_ONE, Q_ONE);
        // saturating coefficients and boxes
        queue_item(OP_ROW, 3'd0, FAC_MIN, FAC_MAX, FAC_MIN, FAC_MAX,
                   '0, '0, '0, '0, '0, '0);
        queue_item(OP_PLANE, 3'd0, FAC_MIN, FAC_MAX, FAC_MIN, FAC_MIN,
                   '0, '0, '0, '0, '0, '0);
        queue_item(OP_TEST, 3'd0, '0, '0, '0, '0,
                   FAC_MIN, FAC_MIN, FAC_MIN, FAC_MAX, FAC_MAX, FAC_MAX);
        queue_item(OP_TEST, 3'd0, '0, '0, '0, '0,
                   FAC_MAX, FAC_MAX, FAC_MAX, FAC_MIN, FAC_MIN, FAC_MIN);
        queue_item(OP_TEST, 3'd0, '1, '1, '1, '1,
                   FAC_MAX, FAC_MAX, FAC_MAX, FAC_MAX, FAC_MAX, FAC_MAX);
    endtask

    task automatic queue_random_part();
        int counted;
        int k;
        int i;
        counted = 0;
        while (counted < ITEM_TARGET) begin
            k = $urandom_range(0, 99);
            if (k < 58) begin
                queue_random(OP_TEST, 3'($urandom_range(0, 7)));
                counted++;
            end else if (k < 64) begin
                // full plane set
                for (i = 0; i < FAC_PLANE_COUNT; i++) queue_random(OP_PLANE, 3'(i));
                counted += FAC_PLANE_COUNT;
            end else if (k < 68) begin
                // full matrix
                for (i = 0; i < FAC_ROWS; i++) queue_random(OP_ROW, 3'(i));
                counted += FAC_ROWS;
            end else if (k < 80) begin
                queue_random(OP_PLANE, 3'($urandom_range(0, FAC_PLANE_COUNT - 1)));
                counted++;
            end else if (k < 88) begin
                queue_random(OP_ROW, 3'($urandom_range(0, FAC_ROWS - 1)));
                counted++;
            end else if (k < 92) begin
                queue_random(OP_UNUSED, 3'($urandom_range(0, 7)));
                counted++;
            end else if (k < 96) begin
                queue_random(OP_PLANE, 3'($urandom_range(FAC_PLANE_COUNT, 7)));
                counted++;
            end else begin
                queue_random(OP_ROW, 3'($urandom_range(FAC_ROWS, 7)));
                counted++;
            end
        end
    endtask

    // sample both channels, predict on input, check on output
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (exp_visible_q.size() == 0) begin
                    $error("visible: no result expected, actual %0d", m_axis_tdata[0]);
                    err_cnt++;
                end else if (m_axis_tdata[0] !== exp_visible_q[0]) begin
                    $error("visible mismatch: expected %0d, actual %0d",
                           exp_visible_q[0], m_axis_tdata[0]);
                    err_cnt++;
                    void'(exp_visible_q.pop_front());
                end else begin
                    void'(exp_visible_q.pop_front());
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_item(s_axis_tuser, s_axis_tdata);
            end
            in_fire  <= s_axis_tvalid && s_axis_tready;
            out_fire <= m_axis_tvalid && m_axis_tready;
        end
    end

    // sender: gaps per item, with a burst phase of no gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                snd_busy = 1'b0;
                snd_gap  = ((items_sent / 120) % 3 == 2) ? 0 : $urandom_range(0, 13);
            end
            if (!snd_busy) begin
                if (snd_gap > 0) begin
                    snd_gap--;
                end else if (items_sent == PAUSE_AT && !pause_done) begin
                    // hold until every outstanding result is back
                    if (exp_visible_q.size() == 0) pause_done = 1'b1;
                end else if (pending_q.size() > 0) begin
                    s_axis_tuser <= pending_q[0].user;
                    s_axis_tdata <= pending_q[0].data;
                    void'(pending_q.pop_front());
                    snd_busy = 1'b1;
                    items_sent++;
                end
            end
            s_axis_tvalid <= snd_busy;
        end
    end

    // receiver: stall per result, one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) begin
                if (results_seen == HOLD_AT) begin
                    rcv_wait = HOLD_CYCLES;
                end else begin
                    rcv_wait = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 13);
                end
            end
            if (rcv_wait > 0) begin
                rcv_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        for (int i = 0; i < FAC_PLANE_COUNT; i++) begin
            plane_nx[i]  = 0;
            plane_ny[i]  = 0;
            plane_nz[i]  = 0;
            plane_off[i] = 0;
        end
        for (int i = 0; i < 4 * FAC_ROWS; i++) world_m[i] = 0;
        queue_directed();
        queue_random_part();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_q.size() != 0 || s_axis_tvalid || exp_visible_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && exp_visible_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
